### design/rsp_pkg.sv
`timescale 1ns / 1ps

package rsp_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned SEED_W = 32;
	// step counts go up to 2047 + 20
	localparam int unsigned CNT_W  = 12;
	localparam int unsigned FLD_W  = 11;

	localparam logic [WORD_W-1:0] START_A = 64'd914489;
	localparam logic [WORD_W-1:0] START_B = 64'd8675416;
	localparam logic [WORD_W-1:0] START_C = 64'd439754684;
	localparam logic [CNT_W-1:0]  EXTRA_STEPS = 12'd20;

	// operations of the shared step unit
	typedef enum logic [1:0] {
		STEP_A,
		STEP_B,
		STEP_C1,
		STEP_C2
	} step_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_A,
		ST_SEED_B,
		ST_SEED_C1,
		ST_SEED_C2,
		ST_DRAW_A,
		ST_DRAW_B,
		ST_DRAW_C1,
		ST_DRAW_C2
	} state_t;

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] w, input int unsigned k);
		rotl = (w << k) | (w >> (WORD_W - k));
	endfunction

endpackage

### design/rsp_ifs.sv
`timescale 1ns / 1ps

interface rsp_cmd_if import rsp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [SEED_W-1:0] seed;

	modport source (output valid, output op, output seed, input ready);
	modport sink   (input valid, input op, input seed, output ready);
endinterface

interface rsp_res_if import rsp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

### design/rsp_step.sv
`timescale 1ns / 1ps

module rsp_step import rsp_pkg::*; (
	input  step_op_t          op,
	input  logic [WORD_W-1:0] word,
	output logic [WORD_W-1:0] result
);

	logic [WORD_W-1:0] opd_x;
	logic [WORD_W-1:0] opd_y;
	logic              sub;
	logic [WORD_W-1:0] sum;

	// operand selection for the single adder
	always_comb begin
		unique case (op)
			STEP_A: begin
				opd_x = rotl(word, 8);
				opd_y = rotl(word, 29);
				sub   = 1'b1;
			end
			STEP_B: begin
				opd_x = rotl(word, 21);
				opd_y = word;
				sub   = 1'b1;
			end
			STEP_C1: begin
				opd_x = rotl(word, 42);
				opd_y = word;
				sub   = 1'b1;
			end
			STEP_C2: begin
				opd_x = word;
				opd_y = rotl(word, 14);
				sub   = 1'b0;
			end
			default: begin
				opd_x = word;
				opd_y = word;
				sub   = 1'b0;
			end
		endcase
	end

	assign sum = opd_x + (sub ? ~opd_y : opd_y) + {{(WORD_W-1){1'b0}}, sub};

	// post rotation only for the b rule
	assign result = (op == STEP_B) ? rotl(sum, 20) : sum;

endmodule

### design/rotate_subtract_prng64_unit.sv
`timescale 1ns / 1ps

// rotate-and-subtract 64-bit generator built from three 64-bit words
// cmd channel: op 0 reseeds from seed, op 1 draws one value; seed ignored on draws
// res channel: one 64-bit value per draw, xor of the three stepped words; reseed gives none
// all arithmetic runs through one shared 64-bit step unit (one adder, fixed rotations)
// the sequencer steps word a, then b, then c; the c rule takes two passes (subtract, add)
// draw: after the accepting edge the unit runs the a, b, c1 and c2 passes in order; the value
//   is registered at the end of the c2 pass; cmd.ready is high only when the sequencer is idle
// reseed: steps a na, b nb and c nc times (c in two passes) with na = seed[31:22]+20,
//   nb = seed[21:11]+20, nc = seed[10:0]+20; all counts come from one step counter
// result sits in an output register: a new item is accepted while it waits
// if the receiver stalls and another draw finishes, the sequencer holds on its last
//   pass until the register frees up, then cmd.ready returns
// reset clears the three words to zero (draws then give zero until a reseed),
//   returns the sequencer to idle and drops res.valid
module rotate_subtract_prng64_unit import rsp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	rsp_cmd_if.sink      cmd,
	rsp_res_if.source    res
);

	state_t            state_q;
	state_t            state_d;
	step_op_t          step_op;
	logic [WORD_W-1:0] step_word;
	logic [WORD_W-1:0] step_res;

	logic [WORD_W-1:0] gen_a_q;
	logic [WORD_W-1:0] gen_b_q;
	logic [WORD_W-1:0] gen_c_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [FLD_W-1:0]  seed_b_q;
	logic [FLD_W-1:0]  seed_c_q;
	logic              res_valid_q;
	logic [WORD_W-1:0] res_value_q;

	logic              cmd_take;
	logic              cnt_last;
	logic              res_free;
	logic              draw_done;

	assign cmd_take  = cmd.valid && cmd.ready;
	assign cnt_last  = (cnt_q == {{(CNT_W-1){1'b0}}, 1'b1});
	assign res_free  = !res_valid_q || res.ready;
	assign draw_done = (state_q == ST_DRAW_C2) && res_free;

	assign cmd.ready = (state_q == ST_IDLE);
	assign res.valid = res_valid_q;
	assign res.value = res_value_q;

	// shared step unit
	rsp_step u_step (
		.op     (step_op),
		.word   (step_word),
		.result (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and unit operation
	always_comb begin
		state_d   = state_q;
		step_op   = STEP_A;
		step_word = gen_a_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_take) begin
					state_d = cmd.op ? ST_DRAW_A : ST_SEED_A;
				end
			end
			ST_SEED_A: begin
				if (cnt_last) begin
					state_d = ST_SEED_B;
				end
			end
			ST_SEED_B: begin
				step_op   = STEP_B;
				step_word = gen_b_q;
				if (cnt_last) begin
					state_d = ST_SEED_C1;
				end
			end
			ST_SEED_C1: begin
				step_op   = STEP_C1;
				step_word = gen_c_q;
				state_d   = ST_SEED_C2;
			end
			ST_SEED_C2: begin
				step_op   = STEP_C2;
				step_word = gen_c_q;
				state_d   = cnt_last ? ST_IDLE : ST_SEED_C1;
			end
			ST_DRAW_A: begin
				state_d = ST_DRAW_B;
			end
			ST_DRAW_B: begin
				step_op   = STEP_B;
				step_word = gen_b_q;
				state_d   = ST_DRAW_C1;
			end
			ST_DRAW_C1: begin
				step_op   = STEP_C1;
				step_word = gen_c_q;
				state_d   = ST_DRAW_C2;
			end
			ST_DRAW_C2: begin
				step_op   = STEP_C2;
				step_word = gen_c_q;
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// generator words; c holds the intermediate t between its two passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_a_q <= '0;
			gen_b_q <= '0;
			gen_c_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_take && !cmd.op) begin
						gen_a_q <= START_A;
						gen_b_q <= START_B;
						gen_c_q <= START_C;
					end
				end
				ST_SEED_A, ST_DRAW_A: gen_a_q <= step_res;
				ST_SEED_B, ST_DRAW_B: gen_b_q <= step_res;
				ST_SEED_C1, ST_SEED_C2, ST_DRAW_C1: gen_c_q <= step_res;
				ST_DRAW_C2: begin
					if (res_free) begin
						gen_c_q <= step_res;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// step counter, reloaded from the stored seed fields at each word change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_take && !cmd.op) begin
						cnt_q <= CNT_W'({2'b00, cmd.seed[31:22]}) + EXTRA_STEPS;
					end
				end
				ST_SEED_A: begin
					cnt_q <= cnt_last ? (CNT_W'(seed_b_q) + EXTRA_STEPS) : (cnt_q - 1'b1);
				end
				ST_SEED_B: begin
					cnt_q <= cnt_last ? (CNT_W'(seed_c_q) + EXTRA_STEPS) : (cnt_q - 1'b1);
				end
				ST_SEED_C2: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take && !cmd.op) begin
			seed_b_q <= cmd.seed[21:11];
			seed_c_q <= cmd.seed[10:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (draw_done) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (draw_done) begin
			res_value_q <= gen_a_q ^ gen_b_q ^ step_res;
		end
	end

	// a reseed counter never runs out while stepping
	a_seed_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEED_A || state_q == ST_SEED_B || state_q == ST_SEED_C1 ||
		 state_q == ST_SEED_C2) |-> cnt_q != '0)
		else $error("step counter empty during reseed");

	// a reseed loads the start constants
	a_seed_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && !cmd.op) |=> (state_q == ST_SEED_A && gen_a_q == START_A &&
		 gen_b_q == START_B && gen_c_q == START_C))
		else $error("reseed did not load start words");

	// a result appears only at the end of a draw
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_DRAW_C2)
		else $error("result without a finished draw");

	// a finished draw never overwrites a waiting result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res.ready && state_q == ST_DRAW_C2) |=>
		(state_q == ST_DRAW_C2 && $stable(res_value_q)))
		else $error("pending result overwritten");

endmodule
